FILE: sv/stereo_feedback_echo_assert.svh
// assertion macros for the stereo feedback echo block
// no dependencies; included by the modules that carry assertions
`ifndef STEREO_FEEDBACK_ECHO_ASSERT_SVH
`define STEREO_FEEDBACK_ECHO_ASSERT_SVH

// condition must never hold while out of reset
`define SFE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sfe assertion failed");

// antecedent in one cycle implies consequent in the next
`define SFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfe assertion failed");

// antecedent implies consequent in the same cycle
`define SFE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfe assertion failed");

`endif

FILE: sv/sfe_pkg.sv
// shared constants and types for the stereo feedback echo block
// no dependencies
package sfe_pkg;

    localparam int MAX_DELAY_DEF   = 65536;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int VOL_W      = 16;

    localparam int LEN_RESET = 4800;
    localparam logic [VOL_W-1:0] VOL_RESET = 16'd16384;
    localparam logic [VOL_W-1:0] VOL_ONE   = 16'd32768;

    localparam int FRAC_BITS = 15;
    localparam int RND_HALF  = 16384;

    localparam int OFIFO_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_LENGTH = 2'd0,
        REG_ECHO_VOLUME  = 2'd1
    } t_cfg_reg;

endpackage

FILE: sv/sfe_store.sv
// one channel of the circular delay store, one write and one registered read port
// uses no package items
module sfe_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/sfe_mix.sv
// per-channel echo mix: stored + round((in - stored) * vol / 2^15)
// depends on sfe_pkg for the volume width and rounding constants
module sfe_mix #(
    parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    input  logic [SAMPLE_BITS-1:0]      i_stored,
    input  logic [sfe_pkg::VOL_W-1:0]   i_vol,
    output logic [SAMPLE_BITS-1:0]      o_mix
);

    localparam int PROD_W = SAMPLE_BITS + sfe_pkg::VOL_W + 2;

    logic signed [SAMPLE_BITS:0]        diff;
    logic signed [sfe_pkg::VOL_W:0]     vol_s;
    logic signed [PROD_W-1:0]           prod;
    logic signed [PROD_W-1:0]           rnd;
    logic signed [PROD_W-1:0]           shifted;

    always_comb begin
        diff    = $signed({i_sample[SAMPLE_BITS-1], i_sample})
                - $signed({i_stored[SAMPLE_BITS-1], i_stored});
        vol_s   = $signed({1'b0, i_vol});
        prod    = diff * vol_s;
        rnd     = prod + $signed(PROD_W'(sfe_pkg::RND_HALF));
        shifted = rnd >>> sfe_pkg::FRAC_BITS;
        o_mix   = i_stored + shifted[SAMPLE_BITS-1:0];
    end

endmodule

FILE: sv/sfe_ofifo.sv
// small output queue decoupling the mix stage from the result channel
// depends on sfe_pkg for its depth and on the assertion macro header
`include "stereo_feedback_echo_assert.svh"

module sfe_ofifo #(
    parameter int WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    input  logic [WIDTH-1:0]                       i_push_data,
    output logic [$clog2(sfe_pkg::OFIFO_DEPTH+1)-1:0] o_count,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [WIDTH-1:0]                       o_data
);

    localparam int DEPTH = sfe_pkg::OFIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             pop;

    always_comb begin
        pop     = (r_count != '0) && i_ready;
        n_count = r_count + CW'(i_push) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    `SFE_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && (r_count == CW'(DEPTH)))
    `SFE_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, 1'b1, r_count == $past(n_count))
    `SFE_ASSERT_SAME(a_ptr_gap, i_clk, i_rst_n, (r_count == '0) || (r_count == CW'(DEPTH)), r_wr_ptr == r_rd_ptr)

endmodule

FILE: sv/stereo_feedback_echo.sv
// result path: read-stage registers, then the output queue, then the result channel
// throughput: one stereo item per cycle while the output queue has room, set by one store read
// and one write per cycle with forwarding of the last written entry and a four-entry output queue
// reset: synchronous; stores need no clearing pass, a fill count of written entries
// makes unwritten entries read as zero; registers return to 4800 (at most MAX_DELAY) and 16384
// depends on sfe_pkg, sfe_store, sfe_mix, sfe_ofifo and the assertion macro header
`include "stereo_feedback_echo_assert.svh"

module stereo_feedback_echo #(
    parameter int MAX_DELAY   = sfe_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [sfe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [SAMPLE_BITS-1:0]          i_left_sample,
    input  logic [SAMPLE_BITS-1:0]          i_right_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [SAMPLE_BITS-1:0]          o_left_out,
    output logic [SAMPLE_BITS-1:0]          o_right_out
);

    localparam int AW    = $clog2(MAX_DELAY);
    localparam int FW    = AW + 1;
    localparam int LEN_W = (FW > sfe_pkg::CFG_DATA_W) ? FW : sfe_pkg::CFG_DATA_W;
    localparam int CW    = $clog2(sfe_pkg::OFIFO_DEPTH + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DELAY);
    localparam logic [LEN_W-1:0] LEN_RST = (sfe_pkg::LEN_RESET > MAX_DELAY) ?
                                           MAX_LEN : LEN_W'(sfe_pkg::LEN_RESET);

    // configuration, held already clamped
    logic [LEN_W-1:0]          r_len;
    logic [sfe_pkg::VOL_W-1:0] r_vol;
    logic [LEN_W-1:0]          cfg_len;
    logic [sfe_pkg::VOL_W-1:0] cfg_vol;

    always_comb begin
        cfg_len = LEN_W'(i_cfg_data);
        if (cfg_len == '0) begin
            cfg_len = LEN_W'(1);
        end else if (cfg_len > MAX_LEN) begin
            cfg_len = MAX_LEN;
        end
        cfg_vol = i_cfg_data[sfe_pkg::VOL_W-1:0];
        if (cfg_vol > sfe_pkg::VOL_ONE) begin
            cfg_vol = sfe_pkg::VOL_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RST;
            r_vol <= sfe_pkg::VOL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sfe_pkg::REG_DELAY_LENGTH: r_len <= cfg_len;
                sfe_pkg::REG_ECHO_VOLUME:  r_vol <= cfg_vol;
                default: ;
            endcase
        end
    end

    // read stage: position, fill count, store read
    logic [AW-1:0]          r_pos;
    logic [FW-1:0]          r_fill;
    logic                   r_s1_valid;
    logic [AW-1:0]          r_s1_pos;
    logic                   r_s1_hit;
    logic [SAMPLE_BITS-1:0] r_s1_l;
    logic [SAMPLE_BITS-1:0] r_s1_r;
    logic                   in_acc;
    logic [AW-1:0]          pos_cur;
    logic [LEN_W-1:0]       pos_inc;
    logic [AW-1:0]          pos_nxt;
    logic                   hit;
    logic [CW-1:0]          q_count;
    logic [CW:0]            q_load;

    always_comb begin
        q_load  = {1'b0, q_count} + (CW + 1)'(r_s1_valid);
        o_ready = q_load < (CW + 1)'(sfe_pkg::OFIFO_DEPTH);
        in_acc  = i_valid && o_ready;
        pos_cur = (LEN_W'(r_pos) >= r_len) ? '0 : r_pos;
        pos_inc = LEN_W'(pos_cur) + LEN_W'(1);
        pos_nxt = (pos_inc >= r_len) ? '0 : pos_inc[AW-1:0];
        hit     = FW'(pos_cur) < r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            if (in_acc) begin
                r_pos <= pos_nxt;
                if (!hit) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pos <= pos_cur;
            r_s1_hit <= hit;
            r_s1_l   <= i_left_sample;
            r_s1_r   <= i_right_sample;
        end
    end

    // mix stage with forwarding of the entry written in the previous cycle
    logic                   r_fwd_valid;
    logic [AW-1:0]          r_fwd_pos;
    logic [SAMPLE_BITS-1:0] r_fwd_l;
    logic [SAMPLE_BITS-1:0] r_fwd_r;
    logic [SAMPLE_BITS-1:0] rd_l;
    logic [SAMPLE_BITS-1:0] rd_r;
    logic [SAMPLE_BITS-1:0] st_l;
    logic [SAMPLE_BITS-1:0] st_r;
    logic [SAMPLE_BITS-1:0] mix_l;
    logic [SAMPLE_BITS-1:0] mix_r;
    logic                   fwd;

    always_comb begin
        fwd  = r_fwd_valid && (r_fwd_pos == r_s1_pos);
        st_l = fwd ? r_fwd_l : (r_s1_hit ? rd_l : '0);
        st_r = fwd ? r_fwd_r : (r_s1_hit ? rd_r : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_pos <= r_s1_pos;
        r_fwd_l   <= mix_l;
        r_fwd_r   <= mix_r;
    end

    sfe_store #(.DEPTH(MAX_DELAY), .AW(AW), .WIDTH(SAMPLE_BITS)) u_store_l (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (pos_cur),
        .o_rd_data (rd_l),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_pos),
        .i_wr_data (mix_l)
    );

    sfe_store #(.DEPTH(MAX_DELAY), .AW(AW), .WIDTH(SAMPLE_BITS)) u_store_r (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (pos_cur),
        .o_rd_data (rd_r),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_pos),
        .i_wr_data (mix_r)
    );

    sfe_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_mix_l (
        .i_sample (r_s1_l),
        .i_stored (st_l),
        .i_vol    (r_vol),
        .o_mix    (mix_l)
    );

    sfe_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_mix_r (
        .i_sample (r_s1_r),
        .i_stored (st_r),
        .i_vol    (r_vol),
        .o_mix    (mix_r)
    );

    // result queue
    logic [2*SAMPLE_BITS-1:0] q_data;

    sfe_ofifo #(.WIDTH(2 * SAMPLE_BITS)) u_ofifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_data ({mix_l, mix_r}),
        .o_count     (q_count),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (q_data)
    );

    assign o_left_out  = q_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign o_right_out = q_data[SAMPLE_BITS-1:0];

    `SFE_ASSERT_NEXT(a_acc_to_mix, i_clk, i_rst_n, in_acc, r_s1_valid)
    `SFE_ASSERT_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill > FW'(MAX_DELAY))
    `SFE_ASSERT_SAME(a_miss_no_fwd, i_clk, i_rst_n, r_s1_valid && !r_s1_hit, !fwd)

endmodule
